// File: design/rfom_pkg.sv
`default_nettype none

package rfom_pkg;

	// Defaults for the top-level parameters.
	localparam int RFOM_DEPTH      = 16;
	localparam int RFOM_WORD_WIDTH = 32;

	// Fixed field widths of the channels.
	localparam int PUSH_WORD_W = 32;
	localparam int POP_WORD_W  = 32;
	localparam int CFG_DATA_W  = 5;
	localparam int CFG_IDX_W   = 1;

	// Slot count in use after reset.
	localparam int DEPTH_RESET = 16;

	// Operation codes.
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_IN_USE  = 1'd1;

	typedef enum logic [1:0] {
		MODE_REFUSE    = 2'd0,
		MODE_DROP_NEW  = 2'd1,
		MODE_OVERWRITE = 2'd2
	} overflow_mode_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ERROR       = 2'd1,
		ST_DROPPED     = 2'd2,
		ST_OVERWRITTEN = 2'd3
	} status_t;

	typedef struct packed {
		logic                   kind;
		logic [PUSH_WORD_W-1:0] push_word;
	} op_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [POP_WORD_W-1:0] pop_word;
		logic                  is_empty;
	} res_t;

endpackage

`default_nettype wire

// File: design/rfom_ram.sv
`default_nettype none

module rfom_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/ring_fifo_with_overflow_modes_unit.sv
`default_nettype none

// Channel  Handshake              Payload              Use
// op       op_valid / op_stall    op (op_t)            push or pop request, one item
// res      res_valid / res_stall  res (res_t)          one result item per op item
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data  register write, always ready
//
// One op item is accepted per cycle while op_stall is low, back to back. The slot RAM
// has a registered read port, so an accepted item waits in the middle stage while the
// RAM read is in flight and is loaded into the result register from there.
// Reset empties the buffer, selects the refuse policy and sixteen slots in use
// (capped at DEPTH). A stalled result holds; the middle stage then holds too and
// op_stall rises, so no item is lost and the RAM read data stays put.

module ring_fifo_with_overflow_modes_unit
	import rfom_pkg::*;
#(
	parameter int DEPTH      = RFOM_DEPTH,
	parameter int WORD_WIDTH = RFOM_WORD_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  op_valid,
	output logic                       op_stall,
	input  wire op_t                   op,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output res_t                       res,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W     = $clog2(DEPTH);
	localparam int RST_USED  = (DEPTH_RESET > DEPTH) ? DEPTH : DEPTH_RESET;
	localparam logic [IDX_W-1:0] RST_LAST = IDX_W'(RST_USED - 1);

	// Architectural state: indices, empty flag and configuration.
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             empty_q;
	logic [1:0]       mode_q;
	logic [IDX_W-1:0] last_idx_q;   // highest slot index in use

	// Middle stage: the item has updated the state, the RAM read is in flight.
	logic       valid_s1;
	logic [1:0] status_s1;
	logic       empty_s1;
	logic       pop_ok_s1;

	logic                  res_valid_q;
	res_t                  res_q;
	logic [WORD_WIDTH-1:0] ram_rdata;

	logic accept;
	logic s1_advance;
	logic cfg_we;

	// Next state of the item being accepted.
	logic             full;
	logic [IDX_W-1:0] wr_adv;
	logic [IDX_W-1:0] rd_adv;
	logic [IDX_W-1:0] wr_idx_d;
	logic [IDX_W-1:0] rd_idx_d;
	logic             empty_d;
	logic [1:0]       status_d;
	logic             store;
	logic             pop_ok;
	logic [IDX_W-1:0] cfg_last;

	// Result register frees when empty or taken; the middle stage moves into it then.
	assign s1_advance = !res_valid_q || !res_stall;
	assign op_stall   = valid_s1 && !s1_advance;
	assign accept     = op_valid && !op_stall;
	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;

	assign wr_adv = (wr_idx_q == last_idx_q) ? '0 : wr_idx_q + 1'b1;
	assign rd_adv = (rd_idx_q == last_idx_q) ? '0 : rd_idx_q + 1'b1;
	assign full   = !empty_q && (wr_idx_q == rd_idx_q);

	always_comb begin
		wr_idx_d = wr_idx_q;
		rd_idx_d = rd_idx_q;
		empty_d  = empty_q;
		status_d = ST_OK;
		store    = 1'b0;
		pop_ok   = 1'b0;
		if (op.kind == KIND_PUSH) begin
			if (!full) begin
				store    = 1'b1;
				wr_idx_d = wr_adv;
				empty_d  = 1'b0;
			end else begin
				case (mode_q)
					MODE_DROP_NEW: begin
						status_d = ST_DROPPED;
					end
					MODE_OVERWRITE: begin
						// The oldest word goes, the new one takes its slot.
						store    = 1'b1;
						wr_idx_d = wr_adv;
						rd_idx_d = rd_adv;
						empty_d  = 1'b0;
						status_d = ST_OVERWRITTEN;
					end
					default: begin
						// Refuse, and the unused mode code behaves the same.
						status_d = ST_ERROR;
					end
				endcase
			end
		end else begin
			if (empty_q) begin
				status_d = ST_ERROR;
			end else begin
				pop_ok   = 1'b1;
				rd_idx_d = rd_adv;
				empty_d  = (rd_adv == wr_idx_q);
			end
		end
	end

	// A depth of zero counts as one slot, anything above DEPTH as DEPTH.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_last = '0;
		end else if (32'(cfg_data) > 32'(DEPTH)) begin
			cfg_last = IDX_W'(DEPTH - 1);
		end else begin
			cfg_last = IDX_W'(32'(cfg_data) - 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			empty_q    <= 1'b1;
			mode_q     <= MODE_REFUSE;
			last_idx_q <= RST_LAST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_OVERFLOW_MODE) begin
				mode_q <= cfg_data[1:0];
			end else begin
				// A depth change flushes the buffer; slot contents stay.
				last_idx_q <= cfg_last;
				wr_idx_q   <= '0;
				rd_idx_q   <= '0;
				empty_q    <= 1'b1;
			end
		end else if (accept) begin
			wr_idx_q <= wr_idx_d;
			rd_idx_q <= rd_idx_d;
			empty_q  <= empty_d;
		end
	end

	rfom_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (accept && store),
		.waddr (wr_idx_q),
		.wdata (WORD_WIDTH'(op.push_word)),
		.re    (accept && pop_ok),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			empty_s1  <= empty_d;
			pop_ok_s1 <= pop_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_advance) begin
			res_valid_q <= valid_s1;
		end
	end

	// The RAM word is picked up here, so a later read cannot disturb a held result.
	always_ff @(posedge clk) begin
		if (s1_advance && valid_s1) begin
			res_q.status   <= status_s1;
			res_q.pop_word <= pop_ok_s1 ? POP_WORD_W'(ram_rdata) : '0;
			res_q.is_empty <= empty_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import rfom_pkg::*;

	// The package names only the three defined policies; the fourth code must act as refuse.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Shadow copy of the ring buffer. Every accepted op item is applied here, and the
	// result that the block owes for it is queued; results coming out of the block are
	// compared against the oldest owed one.
	class ring_shadow;
		logic [RFOM_WORD_WIDTH-1:0] slot_words[RFOM_DEPTH];
		int wr_idx;
		int rd_idx;
		bit buffer_empty;
		logic [1:0] mode;
		logic [CFG_DATA_W-1:0] depth_reg;
		res_t owed_results[$];
		int errors;
		int results_checked;
		int full_pushes;
		int empty_pops;

		function new();
			mode = MODE_REFUSE;
			depth_reg = CFG_DATA_W'(DEPTH_RESET);
			wr_idx = 0;
			rd_idx = 0;
			buffer_empty = 1'b1;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_OVERFLOW_MODE: mode = data[1:0];
				CFG_DEPTH_IN_USE: begin
					// A depth write also empties the buffer; slot contents stay.
					depth_reg = data;
					wr_idx = 0;
					rd_idx = 0;
					buffer_empty = 1'b1;
				end
			endcase
		endfunction

		function int next_index(int i);
			int lim;
			lim = (depth_reg == 0) ? 1 : ((depth_reg > RFOM_DEPTH) ? RFOM_DEPTH : depth_reg);
			return (i + 1 >= lim) ? 0 : i + 1;
		endfunction

		function logic [RFOM_WORD_WIDTH-1:0] take_oldest();
			logic [RFOM_WORD_WIDTH-1:0] w;
			w = slot_words[rd_idx];
			rd_idx = next_index(rd_idx);
			if (rd_idx == wr_idx)
				buffer_empty = 1'b1;
			return w;
		endfunction

		function void store(logic [RFOM_WORD_WIDTH-1:0] w);
			slot_words[wr_idx] = w;
			wr_idx = next_index(wr_idx);
			buffer_empty = 1'b0;
		endfunction

		function void apply_op(op_t item);
			res_t want;
			bit is_full;
			want = '0;
			if (item.kind == KIND_PUSH) begin
				// Full means not empty with both indices on the same slot.
				is_full = !buffer_empty && (wr_idx == rd_idx);
				if (!is_full) begin
					store(item.push_word);
				end else begin
					full_pushes++;
					case (mode)
						MODE_DROP_NEW: want.status = ST_DROPPED;
						MODE_OVERWRITE: begin
							void'(take_oldest());
							store(item.push_word);
							want.status = ST_OVERWRITTEN;
						end
						default: want.status = ST_ERROR;
					endcase
				end
			end else if (buffer_empty) begin
				want.status = ST_ERROR;
				empty_pops++;
			end else begin
				want.pop_word = take_oldest();
			end
			want.is_empty = buffer_empty;
			owed_results.push_back(want);
		endfunction

		function void compare_result(res_t got);
			res_t want;
			results_checked++;
			if (owed_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Result %0d arrived with nothing owed: status %0d word %h empty %b",
						results_checked, got.status, got.pop_word, got.is_empty);
				return;
			end
			want = owed_results.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("Result %0d: expected %0d/%h/%b, got %0d/%h/%b",
						results_checked, want.status, want.pop_word, want.is_empty,
						got.status, got.pop_word, got.is_empty);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic op_valid;
	logic op_stall;
	op_t op;
	logic res_valid;
	logic res_stall;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ring_shadow shadow;

	// When steady is set neither side idles, so items go through back to back.
	bit steady;
	int ops_accepted;
	int settings_used;

	// Receiver side state: the long hold-off is counted here, in its own process.
	bit pressure_done;
	int hold_left;

	ring_fifo_with_overflow_modes_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_stall(op_stall),
		.op(op),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous ceiling on the whole run; a correct run ends far earlier.
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	// The receiver stalls at random, about 9 times in a hundred. Once, while the sender is in a
	// push-heavy stretch, it keeps res_stall high until hold_left runs out, so the block fills
	// its pipeline and must stall its input.
	always @(posedge clk) begin
		if (!pressure_done && ops_accepted >= 360) begin
			pressure_done = 1'b1;
			hold_left = 80;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= !steady && ($urandom_range(0, 99) < 9);
		end
	end

	// A result item moves at an edge where valid is high and stall is low. Both are
	// read here before this edge's updates land, so the check sees the values that
	// decided the handshake.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			shadow.compare_result(res);
	end

	// Offers one op item and returns at the edge where it is taken. op_valid is left
	// high so the next item can follow without a gap.
	task automatic send_op(input logic kind, input logic [PUSH_WORD_W-1:0] word);
		op_t item;
		item.kind = kind;
		item.push_word = word;
		while (!steady && $urandom_range(0, 99) < 9) begin
			op_valid <= 1'b0;
			@(posedge clk);
		end
		op_valid <= 1'b1;
		op <= item;
		do @(posedge clk); while (op_stall);
		shadow.apply_op(item);
		ops_accepted++;
	endtask

	// Stops offering and waits until every owed result has come back, plus some margin,
	// so the block is idle for a register write.
	task automatic settle();
		op_valid <= 1'b0;
		do @(posedge clk); while (shadow.owed_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes the policy register and, when asked, the depth register right after it.
	task automatic configure(input logic [CFG_DATA_W-1:0] mode_data, input bit touch_depth,
			input logic [CFG_DATA_W-1:0] depth_data);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_OVERFLOW_MODE;
		cfg_data <= mode_data;
		do @(posedge clk); while (!cfg_ready);
		shadow.write_reg(CFG_OVERFLOW_MODE, mode_data);
		if (touch_depth) begin
			cfg_index <= CFG_DEPTH_IN_USE;
			cfg_data <= depth_data;
			do @(posedge clk); while (!cfg_ready);
			shadow.write_reg(CFG_DEPTH_IN_USE, depth_data);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int depth_choices[10];
		int push_pct[10];
		int phase;
		int n;

		shadow = new();
		arst_n <= 1'b0;
		op_valid <= 1'b0;
		op <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		steady = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. At reset the buffer is empty, refuse policy, sixteen slots.
		// A pop from an empty buffer is an error; then all-zero, all-one and mixed words
		// go in and come out in order, and one more pop fails again.
		send_op(KIND_POP, 32'hFFFF_FFFF);
		send_op(KIND_PUSH, 32'h0000_0000);
		send_op(KIND_PUSH, 32'hFFFF_FFFF);
		send_op(KIND_PUSH, 32'hA5A5_A5A5);
		send_op(KIND_POP, 32'h0000_0000);
		send_op(KIND_POP, 32'h5A5A_5A5A);
		send_op(KIND_POP, 32'hFFFF_FFFF);
		send_op(KIND_POP, 32'h1234_5678);

		// Two slots in refuse mode: the third push meets a full buffer and is refused.
		settle();
		configure(CFG_DATA_W'(MODE_REFUSE), 1'b1, 5'd2);
		send_op(KIND_PUSH, 32'h1234_5678);
		send_op(KIND_PUSH, 32'h9ABC_DEF0);
		send_op(KIND_PUSH, 32'hDEAD_BEEF);
		send_op(KIND_POP, 32'h0);
		send_op(KIND_POP, 32'h0);
		send_op(KIND_POP, 32'h0);

		// Policy change alone does not flush: the new word is dropped when full.
		settle();
		configure(CFG_DATA_W'(MODE_DROP_NEW), 1'b0, '0);
		send_op(KIND_PUSH, 32'h0000_0001);
		send_op(KIND_PUSH, 32'h0000_0002);
		send_op(KIND_PUSH, 32'h0000_0003);
		send_op(KIND_POP, 32'h0);

		// Depth zero is used as one slot; overwrite replaces the only word.
		settle();
		configure(CFG_DATA_W'(MODE_OVERWRITE), 1'b1, 5'd0);
		send_op(KIND_PUSH, 32'hCAFE_F00D);
		send_op(KIND_PUSH, 32'h0BAD_C0DE);
		send_op(KIND_POP, 32'h0);

		// The unused policy code, written with every data bit set, acts as refuse.
		settle();
		configure({3'b111, MODE_UNUSED}, 1'b1, 5'd1);
		send_op(KIND_PUSH, 32'h5555_5555);
		send_op(KIND_PUSH, 32'hAAAA_AAAA);
		send_op(KIND_POP, 32'h0);

		// Random part. Each phase picks a policy (with random upper data bits) and a
		// depth, including zero and values above the slot count, and a push ratio that
		// drives the buffer toward full or empty. Halfway through, the policy changes
		// without a flush. Phase 3 runs with no idling on either side.
		depth_choices = '{16, 1, 0, 31, 2, 5, 16, 3, 17, 8};
		push_pct = '{50, 80, 20, 65, 90, 35, 50, 75, 10, 55};
		for (phase = 0; phase < 10; phase++) begin
			settle();
			steady = (phase == 3);
			configure({3'($urandom_range(0, 7)), 2'(phase % 4)}, 1'b1,
				CFG_DATA_W'(depth_choices[phase]));
			for (n = 0; n < 80; n++) begin
				if (n == 40) begin
					settle();
					configure(CFG_DATA_W'($urandom_range(0, 31)), 1'b0, '0);
				end
				send_op(($urandom_range(0, 99) < push_pct[phase]) ? KIND_PUSH : KIND_POP,
					$urandom());
			end
		end
		steady = 1'b0;

		settle();
		$display("Ran %0d op items through %0d register settings and checked %0d results.",
			ops_accepted, settings_used, shadow.results_checked);
		$display("Pushes into a full buffer: %0d; pops from an empty buffer: %0d.",
			shadow.full_pushes, shadow.empty_pops);
		if (shadow.errors == 0 && shadow.owed_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
